FILE: hdl/mvt_pkg.sv
`timescale 1ns / 1ps

package mvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int NUM_ELEM  = 4;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + $clog2(NUM_ELEM);
    localparam int NUM_REGS  = 2 * NUM_ELEM / 2 * 2;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);
    localparam int CFG_W     = 2 * DATA_W;

    localparam logic OP_MAT_COL = 1'b0;
    localparam logic OP_ROW_MAT = 1'b1;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic [NUM_REGS-1:0][CFG_W-1:0]    mat_t;
    typedef logic [NUM_ELEM-1:0][DATA_W-1:0]   vec_t;
    typedef logic [NUM_ELEM-1:0][PROD_W-1:0]   prod_t;
    typedef logic [NUM_ELEM-1:0][ACC_W-1:0]    acc_t;

    localparam logic [CFG_W-1:0] Q_ONE    = CFG_W'(1) << FRAC_BITS;
    localparam logic [CFG_W-1:0] Q_ONE_HI = Q_ONE << DATA_W;
    localparam mat_t MAT_RESET = {Q_ONE_HI, CFG_W'(0), Q_ONE, CFG_W'(0),
                                  CFG_W'(0), Q_ONE_HI, CFG_W'(0), Q_ONE};

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_w;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               overflow;
    } out_t;

    // token handed from cell to cell: remaining vector elements, running sums
    typedef struct packed {
        logic op;
        vec_t vec;
        acc_t acc;
    } tok_t;

endpackage

FILE: hdl/matrix_vector_transform_4x4.sv
`timescale 1ns / 1ps

// Transforms Q16.16 4-vectors by a 4x4 matrix held column-major in eight
// 64-bit registers (two rows per register, lower row in the low half).
// Write the matrix through cfg_we/cfg_index/cfg_data while no request is
// in flight; writes take effect at once, with no wait and no read-back.
// Requests enter on vec_valid/vec_ready with vec_data (opcode 0: matrix
// times column vector, opcode 1: row vector times matrix); results leave
// on res_valid/res_ready with res_data, saturated, overflow set if any
// element clipped.
// Throughput: one request per cycle while res_ready stays high. A request
// passes through four cells of two stages each (multiply, then accumulate)
// and then through the saturating output register.
// When res_ready is low the chain fills up stage by stage; vec_ready falls
// only once every stage holds a request. Reset empties the chain and
// loads the identity matrix.
module matrix_vector_transform_4x4 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            vec_valid,
    output logic                            vec_ready,
    input  mvt_pkg::in_t                    vec_data,
    output logic                            res_valid,
    input  logic                            res_ready,
    output mvt_pkg::out_t                   res_data,
    input  logic                            cfg_we,
    input  logic [mvt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mvt_pkg::CFG_W-1:0]       cfg_data
);

    // element of column c, row r
    function automatic logic [mvt_pkg::DATA_W-1:0] mat_elem(
        input mvt_pkg::mat_t m,
        input logic [1:0]    c,
        input logic [1:0]    r
    );
        logic [mvt_pkg::CFG_W-1:0] w;
        w = m[{c, r[1]}];
        return r[0] ? w[mvt_pkg::CFG_W-1:mvt_pkg::DATA_W] : w[mvt_pkg::DATA_W-1:0];
    endfunction

    mvt_pkg::mat_t   cfg_reg;
    mvt_pkg::vec_t   coef_col [mvt_pkg::NUM_ELEM];
    mvt_pkg::vec_t   coef_row [mvt_pkg::NUM_ELEM];
    mvt_pkg::tok_t   chain_tok [mvt_pkg::NUM_ELEM+1];
    logic [mvt_pkg::NUM_ELEM:0] chain_vld;
    logic [mvt_pkg::NUM_ELEM:0] chain_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= mvt_pkg::MAT_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // cell k handles vector element k
    always_comb
    begin
        for (int k = 0; k < mvt_pkg::NUM_ELEM; k++)
        begin
            for (int i = 0; i < mvt_pkg::NUM_ELEM; i++)
            begin
                coef_col[k][i] = mat_elem(cfg_reg, 2'(k), 2'(i));
                coef_row[k][i] = mat_elem(cfg_reg, 2'(i), 2'(k));
            end
        end
    end

    always_comb
    begin
        chain_tok[0].op     = vec_data.opcode;
        chain_tok[0].vec[0] = vec_data.in_x;
        chain_tok[0].vec[1] = vec_data.in_y;
        chain_tok[0].vec[2] = vec_data.in_z;
        chain_tok[0].vec[3] = vec_data.in_w;
        chain_tok[0].acc    = '0;
    end

    assign chain_vld[0] = vec_valid;
    assign vec_ready    = chain_rdy[0];

    for (genvar k = 0; k < mvt_pkg::NUM_ELEM; k++)
    begin : g_cell
        mvt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .prev_valid (chain_vld[k]),
            .prev_ready (chain_rdy[k]),
            .prev_tok   (chain_tok[k]),
            .coef_col   (coef_col[k]),
            .coef_row   (coef_row[k]),
            .next_valid (chain_vld[k+1]),
            .next_ready (chain_rdy[k+1]),
            .next_tok   (chain_tok[k+1])
        );
    end

    mvt_sat u_sat (
        .clk        (clk),
        .rst_n      (rst_n),
        .prev_valid (chain_vld[mvt_pkg::NUM_ELEM]),
        .prev_ready (chain_rdy[mvt_pkg::NUM_ELEM]),
        .prev_tok   (chain_tok[mvt_pkg::NUM_ELEM]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> cfg_reg[$past(cfg_index)] == $past(cfg_data))
        else $error("matrix register write lost");

endmodule

FILE: hdl/mvt_cell.sv
`timescale 1ns / 1ps

module mvt_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          prev_valid,
    output logic          prev_ready,
    input  mvt_pkg::tok_t prev_tok,
    input  mvt_pkg::vec_t coef_col,
    input  mvt_pkg::vec_t coef_row,
    output logic          next_valid,
    input  logic          next_ready,
    output mvt_pkg::tok_t next_tok
);

    function automatic logic [mvt_pkg::PROD_W-1:0] smul(
        input logic signed [mvt_pkg::DATA_W-1:0] a,
        input logic signed [mvt_pkg::DATA_W-1:0] b
    );
        logic signed [mvt_pkg::PROD_W-1:0] p;
        p = a * b;
        return p;
    endfunction

    logic            s1_vld_reg;
    logic            s2_vld_reg;
    logic            s1_en;
    logic            s2_en;
    mvt_pkg::vec_t   sel_coef;
    mvt_pkg::prod_t  s1_prod_reg;
    mvt_pkg::prod_t  s1_prod_next;
    mvt_pkg::tok_t   s1_tok_reg;
    mvt_pkg::tok_t   s1_tok_next;
    mvt_pkg::tok_t   s2_tok_reg;
    mvt_pkg::tok_t   s2_tok_next;

    assign s2_en      = !s2_vld_reg || next_ready;
    assign s1_en      = !s1_vld_reg || s2_en;
    assign prev_ready = s1_en;
    assign next_valid = s2_vld_reg;
    assign next_tok   = s2_tok_reg;

    // stage 1: scale the selected coefficients by this cell's vector element
    always_comb
    begin
        case (prev_tok.op)
            mvt_pkg::OP_MAT_COL: sel_coef = coef_col;
            mvt_pkg::OP_ROW_MAT: sel_coef = coef_row;
            default:             sel_coef = coef_col;
        endcase
        s1_tok_next     = prev_tok;
        s1_tok_next.vec = prev_tok.vec >> mvt_pkg::DATA_W;
        for (int i = 0; i < mvt_pkg::NUM_ELEM; i++)
        begin
            s1_prod_next[i] = smul(sel_coef[i], prev_tok.vec[0]);
        end
    end

    // stage 2: add products into the running sums
    always_comb
    begin
        s2_tok_next = s1_tok_reg;
        for (int i = 0; i < mvt_pkg::NUM_ELEM; i++)
        begin
            s2_tok_next.acc[i] = s1_tok_reg.acc[i]
                + {{(mvt_pkg::ACC_W - mvt_pkg::PROD_W){s1_prod_reg[i][mvt_pkg::PROD_W-1]}},
                   s1_prod_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_vld_reg <= prev_valid;
            end
            if (s2_en)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && prev_valid)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_tok_reg  <= s1_tok_next;
        end
        if (s2_en && s1_vld_reg)
        begin
            s2_tok_reg <= s2_tok_next;
        end
    end

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && !s2_en |=> s1_vld_reg && $stable(s1_tok_reg) && $stable(s1_prod_reg))
        else $error("stalled stage 1 lost or changed its data");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !prev_ready |-> s1_vld_reg && s2_vld_reg)
        else $error("cell refused a request with a free stage");

endmodule

FILE: hdl/mvt_sat.sv
`timescale 1ns / 1ps

module mvt_sat (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          prev_valid,
    output logic          prev_ready,
    input  mvt_pkg::tok_t prev_tok,
    output logic          res_valid,
    input  logic          res_ready,
    output mvt_pkg::out_t res_data
);

    localparam int HI_W = mvt_pkg::ACC_W - mvt_pkg::FRAC_BITS - mvt_pkg::DATA_W + 1;

    logic                out_vld_reg;
    logic                out_en;
    mvt_pkg::out_t       out_reg;
    mvt_pkg::out_t       out_next;
    mvt_pkg::vec_t       elem;
    logic [mvt_pkg::NUM_ELEM-1:0] clip;
    logic [HI_W-1:0]     hi;

    assign out_en     = !out_vld_reg || res_ready;
    assign prev_ready = out_en;
    assign res_valid  = out_vld_reg;
    assign res_data   = out_reg;

    // floor shift by the fraction width is a bit slice; clip when the
    // upper bits are not all copies of the sign
    always_comb
    begin
        for (int i = 0; i < mvt_pkg::NUM_ELEM; i++)
        begin
            hi = prev_tok.acc[i][mvt_pkg::ACC_W-1 -: HI_W];
            clip[i] = !((&hi) || !(|hi));
            if (!clip[i])
            begin
                elem[i] = prev_tok.acc[i][mvt_pkg::FRAC_BITS +: mvt_pkg::DATA_W];
            end
            else if (prev_tok.acc[i][mvt_pkg::ACC_W-1])
            begin
                elem[i] = mvt_pkg::SAT_MIN;
            end
            else
            begin
                elem[i] = mvt_pkg::SAT_MAX;
            end
        end
        out_next.out_x    = elem[0];
        out_next.out_y    = elem[1];
        out_next.out_z    = elem[2];
        out_next.out_w    = elem[3];
        out_next.overflow = |clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_vld_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && prev_valid)
        begin
            out_reg <= out_next;
        end
    end

    a_ovf_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.overflow |->
            out_reg.out_x == mvt_pkg::SAT_MAX || out_reg.out_x == mvt_pkg::SAT_MIN ||
            out_reg.out_y == mvt_pkg::SAT_MAX || out_reg.out_y == mvt_pkg::SAT_MIN ||
            out_reg.out_z == mvt_pkg::SAT_MAX || out_reg.out_z == mvt_pkg::SAT_MIN ||
            out_reg.out_w == mvt_pkg::SAT_MAX || out_reg.out_w == mvt_pkg::SAT_MIN)
        else $error("overflow flagged without a clipped element");

    a_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> prev_ready)
        else $error("empty output register blocked the chain");

endmodule
